[sv/llp_pkg.sv]
// Shared types, constants and the LL(1) production table for the expression parser.
package llp_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    // Field widths
    localparam int TOK_W  = 5;
    localparam int SYM_W  = 6;
    localparam int NERR_W = 11;
    localparam int ERR_W  = 16;

    localparam logic [NERR_W-1:0] NERR_MAX = {NERR_W{1'b1}};
    localparam logic [ERR_W-1:0]  ERR_MAX  = {ERR_W{1'b1}};

    // Terminal codes
    localparam logic [TOK_W-1:0] T_END   = 5'd0;
    localparam logic [TOK_W-1:0] T_ID    = 5'd1;
    localparam logic [TOK_W-1:0] T_INT   = 5'd2;
    localparam logic [TOK_W-1:0] T_FLT   = 5'd3;
    localparam logic [TOK_W-1:0] T_TRUE  = 5'd4;
    localparam logic [TOK_W-1:0] T_FALSE = 5'd5;
    localparam logic [TOK_W-1:0] T_PLUS  = 5'd6;
    localparam logic [TOK_W-1:0] T_MINUS = 5'd7;
    localparam logic [TOK_W-1:0] T_STAR  = 5'd8;
    localparam logic [TOK_W-1:0] T_SLASH = 5'd9;
    localparam logic [TOK_W-1:0] T_MOD   = 5'd10;
    localparam logic [TOK_W-1:0] T_EQ    = 5'd11;
    localparam logic [TOK_W-1:0] T_NEQ   = 5'd12;
    localparam logic [TOK_W-1:0] T_LT    = 5'd13;
    localparam logic [TOK_W-1:0] T_GT    = 5'd14;
    localparam logic [TOK_W-1:0] T_LE    = 5'd15;
    localparam logic [TOK_W-1:0] T_GE    = 5'd16;
    localparam logic [TOK_W-1:0] T_AND   = 5'd17;
    localparam logic [TOK_W-1:0] T_OR    = 5'd18;
    localparam logic [TOK_W-1:0] T_NOT   = 5'd19;
    localparam logic [TOK_W-1:0] T_LP    = 5'd20;
    localparam logic [TOK_W-1:0] T_RP    = 5'd21;
    localparam logic [TOK_W-1:0] T_SEMI  = 5'd22;
    localparam logic [TOK_W-1:0] T_COMMA = 5'd23;

    // Nonterminal codes
    localparam logic [TOK_W-1:0] N_EXPR  = 5'd0;
    localparam logic [TOK_W-1:0] N_LOR   = 5'd1;
    localparam logic [TOK_W-1:0] N_LORP  = 5'd2;
    localparam logic [TOK_W-1:0] N_LAND  = 5'd3;
    localparam logic [TOK_W-1:0] N_LANDP = 5'd4;
    localparam logic [TOK_W-1:0] N_EQ    = 5'd5;
    localparam logic [TOK_W-1:0] N_EQP   = 5'd6;
    localparam logic [TOK_W-1:0] N_REL   = 5'd7;
    localparam logic [TOK_W-1:0] N_RELP  = 5'd8;
    localparam logic [TOK_W-1:0] N_ADD   = 5'd9;
    localparam logic [TOK_W-1:0] N_ADDP  = 5'd10;
    localparam logic [TOK_W-1:0] N_MULT  = 5'd11;
    localparam logic [TOK_W-1:0] N_MULTP = 5'd12;
    localparam logic [TOK_W-1:0] N_UNARY = 5'd13;
    localparam logic [TOK_W-1:0] N_PRIM  = 5'd14;

    // Token sets, one bit per token code
    localparam logic [31:0] SET_ATOM  = (32'd1 << T_ID) | (32'd1 << T_INT) | (32'd1 << T_FLT)
                                      | (32'd1 << T_TRUE) | (32'd1 << T_FALSE);
    localparam logic [31:0] SET_FIRST = SET_ATOM | (32'd1 << T_LP) | (32'd1 << T_NOT)
                                      | (32'd1 << T_MINUS);
    localparam logic [31:0] FOL_LOR   = (32'd1 << T_END) | (32'd1 << T_RP) | (32'd1 << T_SEMI)
                                      | (32'd1 << T_COMMA);
    localparam logic [31:0] FOL_LAND  = FOL_LOR | (32'd1 << T_OR);
    localparam logic [31:0] FOL_EQ    = FOL_LAND | (32'd1 << T_AND);
    localparam logic [31:0] FOL_REL   = FOL_EQ | (32'd1 << T_EQ) | (32'd1 << T_NEQ);
    localparam logic [31:0] FOL_ADD   = FOL_REL | (32'd1 << T_LT) | (32'd1 << T_GT)
                                      | (32'd1 << T_LE) | (32'd1 << T_GE);
    localparam logic [31:0] FOL_MULT  = FOL_ADD | (32'd1 << T_PLUS) | (32'd1 << T_MINUS);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_PUSH,
        ST_DONE
    } llp_state_t;

    // One production: cnt symbols, s0 pushed first, the last one ends on top
    typedef struct packed {
        logic             ok;
        logic [1:0]       cnt;
        logic [SYM_W-1:0] s0;
        logic [SYM_W-1:0] s1;
        logic [SYM_W-1:0] s2;
    } expand_t;

    // Per-token result handed from the sequencer to the output register
    typedef struct packed {
        logic              overflow;
        logic              complete;
        logic [ERR_W-1:0]  error_total;
        logic [NERR_W-1:0] new_errors;
        logic              matched;
    } result_t;

    function automatic logic [SYM_W-1:0] nt_sym(input logic [TOK_W-1:0] n);
        return {1'b1, n};
    endfunction

    function automatic logic [SYM_W-1:0] t_sym(input logic [TOK_W-1:0] t);
        return {1'b0, t};
    endfunction

    // Production lookup for nonterminal nt on lookahead tok
    function automatic expand_t expand_nt(input logic [TOK_W-1:0] nt,
                                          input logic [TOK_W-1:0] tok);
        expand_t     e;
        logic [31:0] m;
        e = '0;
        m = 32'd1 << tok;
        case (nt)
            N_EXPR: begin
                if (|(m & SET_FIRST)) begin
                    e.ok = 1'b1; e.cnt = 2'd1; e.s0 = nt_sym(N_LOR);
                end
            end
            N_LOR: begin
                if (|(m & SET_FIRST)) begin
                    e.ok = 1'b1; e.cnt = 2'd2; e.s0 = nt_sym(N_LORP); e.s1 = nt_sym(N_LAND);
                end
            end
            N_LORP: begin
                if (tok == T_OR) begin
                    e.ok = 1'b1; e.cnt = 2'd3;
                    e.s0 = nt_sym(N_LORP); e.s1 = nt_sym(N_LAND); e.s2 = t_sym(tok);
                end else begin
                    e.ok = |(m & FOL_LOR);
                end
            end
            N_LAND: begin
                if (|(m & SET_FIRST)) begin
                    e.ok = 1'b1; e.cnt = 2'd2; e.s0 = nt_sym(N_LANDP); e.s1 = nt_sym(N_EQ);
                end
            end
            N_LANDP: begin
                if (tok == T_AND) begin
                    e.ok = 1'b1; e.cnt = 2'd3;
                    e.s0 = nt_sym(N_LANDP); e.s1 = nt_sym(N_EQ); e.s2 = t_sym(tok);
                end else begin
                    e.ok = |(m & FOL_LAND);
                end
            end
            N_EQ: begin
                if (|(m & SET_FIRST)) begin
                    e.ok = 1'b1; e.cnt = 2'd2; e.s0 = nt_sym(N_EQP); e.s1 = nt_sym(N_REL);
                end
            end
            N_EQP: begin
                if (tok == T_EQ || tok == T_NEQ) begin
                    e.ok = 1'b1; e.cnt = 2'd3;
                    e.s0 = nt_sym(N_EQP); e.s1 = nt_sym(N_REL); e.s2 = t_sym(tok);
                end else begin
                    e.ok = |(m & FOL_EQ);
                end
            end
            N_REL: begin
                if (|(m & SET_FIRST)) begin
                    e.ok = 1'b1; e.cnt = 2'd2; e.s0 = nt_sym(N_RELP); e.s1 = nt_sym(N_ADD);
                end
            end
            N_RELP: begin
                if (tok == T_LT || tok == T_GT || tok == T_LE || tok == T_GE) begin
                    e.ok = 1'b1; e.cnt = 2'd3;
                    e.s0 = nt_sym(N_RELP); e.s1 = nt_sym(N_ADD); e.s2 = t_sym(tok);
                end else begin
                    e.ok = |(m & FOL_REL);
                end
            end
            N_ADD: begin
                if (|(m & SET_FIRST)) begin
                    e.ok = 1'b1; e.cnt = 2'd2; e.s0 = nt_sym(N_ADDP); e.s1 = nt_sym(N_MULT);
                end
            end
            N_ADDP: begin
                if (tok == T_PLUS || tok == T_MINUS) begin
                    e.ok = 1'b1; e.cnt = 2'd3;
                    e.s0 = nt_sym(N_ADDP); e.s1 = nt_sym(N_MULT); e.s2 = t_sym(tok);
                end else begin
                    e.ok = |(m & FOL_ADD);
                end
            end
            N_MULT: begin
                if (|(m & SET_FIRST)) begin
                    e.ok = 1'b1; e.cnt = 2'd2; e.s0 = nt_sym(N_MULTP); e.s1 = nt_sym(N_UNARY);
                end
            end
            N_MULTP: begin
                if (tok == T_STAR || tok == T_SLASH || tok == T_MOD) begin
                    e.ok = 1'b1; e.cnt = 2'd3;
                    e.s0 = nt_sym(N_MULTP); e.s1 = nt_sym(N_UNARY); e.s2 = t_sym(tok);
                end else begin
                    e.ok = |(m & FOL_MULT);
                end
            end
            N_UNARY: begin
                if (tok == T_NOT || tok == T_MINUS) begin
                    e.ok = 1'b1; e.cnt = 2'd2; e.s0 = nt_sym(N_UNARY); e.s1 = t_sym(tok);
                end else if (|(m & (SET_ATOM | (32'd1 << T_LP)))) begin
                    e.ok = 1'b1; e.cnt = 2'd1; e.s0 = nt_sym(N_PRIM);
                end
            end
            N_PRIM: begin
                if (tok == T_LP) begin
                    e.ok = 1'b1; e.cnt = 2'd3;
                    e.s0 = t_sym(T_RP); e.s1 = nt_sym(N_EXPR); e.s2 = t_sym(T_LP);
                end else if (|(m & SET_ATOM)) begin
                    e.ok = 1'b1; e.cnt = 2'd1; e.s0 = t_sym(tok);
                end
            end
            default: begin
                e = '0;
            end
        endcase
        return e;
    endfunction

endpackage

[sv/llp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module llp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/llp_ctrl.sv]
// Parse sequencer: pops, expands and matches symbols on the RAM-held stack.
module llp_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    // token side
    input  logic                        in_valid,
    input  logic [llp_pkg::TOK_W-1:0]   in_token,
    output logic                        in_ready,
    // result side
    output logic                        res_valid,
    output llp_pkg::result_t            res,
    input  logic                        res_ready,
    // stack RAM
    output logic                        ram_we,
    output logic [llp_pkg::ADDR_W-1:0]  ram_waddr,
    output logic [llp_pkg::SYM_W-1:0]   ram_wdata,
    output logic                        ram_re,
    output logic [llp_pkg::ADDR_W-1:0]  ram_raddr,
    input  logic [llp_pkg::SYM_W-1:0]   ram_rdata
);

    llp_pkg::llp_state_t              state_reg, state_next;
    logic [llp_pkg::SP_W-1:0]         sp_reg, sp_next;
    logic [llp_pkg::TOK_W-1:0]        tok_reg, tok_next;
    logic [llp_pkg::SYM_W-1:0]        sym_reg, sym_next;
    logic [llp_pkg::SYM_W-1:0]        pend_reg, pend_next;
    logic                             src_mem_reg, src_mem_next;
    logic                             active_reg, active_next;
    logic                             matched_reg, matched_next;
    logic                             complete_reg, complete_next;
    logic                             ovf_reg, ovf_next;
    logic [llp_pkg::NERR_W-1:0]       nerr_reg, nerr_next;
    logic [llp_pkg::ERR_W-1:0]        err_reg, err_next;

    logic [llp_pkg::SYM_W-1:0]        sym_x;
    llp_pkg::expand_t                 exp_c;
    logic [llp_pkg::SP_W-1:0]         sp_m1;
    logic [llp_pkg::SP_W-1:0]         sp_p1;
    logic [llp_pkg::SP_W:0]           sp_pk;
    logic                             do_pop;
    logic                             bump;
    logic                             sync_tok;

    // Current symbol comes from the RAM after a pop, else from the top register
    assign sym_x    = src_mem_reg ? ram_rdata : sym_reg;
    assign exp_c    = llp_pkg::expand_nt(sym_x[llp_pkg::TOK_W-1:0], tok_reg);
    assign sp_m1    = sp_reg - llp_pkg::SP_W'(1);
    assign sp_p1    = sp_reg + llp_pkg::SP_W'(1);
    assign sp_pk    = {1'b0, sp_reg} + (llp_pkg::SP_W + 1)'(exp_c.cnt);
    assign sync_tok = (tok_reg == llp_pkg::T_END) || (tok_reg == llp_pkg::T_RP)
                   || (tok_reg == llp_pkg::T_SEMI);

    assign res.matched     = matched_reg;
    assign res.new_errors  = nerr_reg;
    assign res.error_total = err_reg;
    assign res.complete    = complete_reg;
    assign res.overflow    = ovf_reg;

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= llp_pkg::ST_IDLE;
            sp_reg     <= '0;
            active_reg <= 1'b0;
            err_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            active_reg <= active_next;
            err_reg    <= err_next;
        end
    end

    // Per-token working registers
    always_ff @(posedge aclk) begin
        tok_reg      <= tok_next;
        sym_reg      <= sym_next;
        pend_reg     <= pend_next;
        src_mem_reg  <= src_mem_next;
        matched_reg  <= matched_next;
        complete_reg <= complete_next;
        ovf_reg      <= ovf_next;
        nerr_reg     <= nerr_next;
    end

    // Next state and stack access
    always_comb begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        tok_next      = tok_reg;
        sym_next      = sym_reg;
        pend_next     = pend_reg;
        src_mem_next  = src_mem_reg;
        active_next   = active_reg;
        matched_next  = matched_reg;
        complete_next = complete_reg;
        ovf_next      = ovf_reg;
        nerr_next     = nerr_reg;
        err_next      = err_reg;
        ram_we        = 1'b0;
        ram_waddr     = sp_reg[llp_pkg::ADDR_W-1:0];
        ram_wdata     = sym_x;
        ram_re        = 1'b0;
        ram_raddr     = sp_m1[llp_pkg::ADDR_W-1:0];
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        do_pop        = 1'b0;
        bump          = 1'b0;

        case (state_reg)
            llp_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    tok_next      = in_token;
                    matched_next  = 1'b0;
                    complete_next = 1'b0;
                    ovf_next      = 1'b0;
                    nerr_next     = '0;
                    if (!active_reg) begin
                        // fresh parse: end marker in RAM, Expr held on top
                        ram_we       = 1'b1;
                        ram_waddr    = '0;
                        ram_wdata    = llp_pkg::t_sym(llp_pkg::T_END);
                        sp_next      = llp_pkg::SP_W'(1);
                        err_next     = '0;
                        active_next  = 1'b1;
                        sym_next     = llp_pkg::nt_sym(llp_pkg::N_EXPR);
                        src_mem_next = 1'b0;
                        state_next   = llp_pkg::ST_EXEC;
                    end else begin
                        state_next = llp_pkg::ST_FETCH;
                    end
                end
            end
            llp_pkg::ST_FETCH: begin
                do_pop = 1'b1;
            end
            llp_pkg::ST_EXEC: begin
                if (!sym_x[llp_pkg::SYM_W-1]) begin
                    // terminal on top
                    if (sym_x[llp_pkg::TOK_W-1:0] == tok_reg) begin
                        matched_next = 1'b1;
                        if (tok_reg != llp_pkg::T_END) begin
                            state_next = llp_pkg::ST_DONE;
                        end else begin
                            do_pop = 1'b1;
                        end
                    end else begin
                        bump   = 1'b1;
                        do_pop = 1'b1;
                    end
                end else if (!exp_c.ok) begin
                    // no production: pop on a sync token, else keep it and skip
                    bump = 1'b1;
                    if (sync_tok) begin
                        do_pop = 1'b1;
                    end else begin
                        ram_we     = 1'b1;
                        sp_next    = sp_p1;
                        state_next = llp_pkg::ST_DONE;
                    end
                end else if (exp_c.cnt == 2'd0) begin
                    do_pop = 1'b1;
                end else if (sp_pk > (llp_pkg::SP_W + 1)'(llp_pkg::STACK_DEPTH)) begin
                    ovf_next    = 1'b1;
                    sp_next     = '0;
                    active_next = 1'b0;
                    state_next  = llp_pkg::ST_DONE;
                end else if (exp_c.cnt == 2'd1) begin
                    sym_next     = exp_c.s0;
                    src_mem_next = 1'b0;
                end else if (exp_c.cnt == 2'd2) begin
                    ram_we       = 1'b1;
                    ram_wdata    = exp_c.s0;
                    sp_next      = sp_p1;
                    sym_next     = exp_c.s1;
                    src_mem_next = 1'b0;
                end else begin
                    ram_we       = 1'b1;
                    ram_wdata    = exp_c.s0;
                    sp_next      = sp_p1;
                    pend_next    = exp_c.s1;
                    sym_next     = exp_c.s2;
                    src_mem_next = 1'b0;
                    state_next   = llp_pkg::ST_PUSH;
                end
            end
            llp_pkg::ST_PUSH: begin
                // second symbol of a three-symbol production
                ram_we     = 1'b1;
                ram_wdata  = pend_reg;
                sp_next    = sp_p1;
                state_next = llp_pkg::ST_EXEC;
            end
            llp_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = llp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = llp_pkg::ST_IDLE;
            end
        endcase

        // saturating error counts
        if (bump) begin
            if (nerr_reg != llp_pkg::NERR_MAX) nerr_next = nerr_reg + llp_pkg::NERR_W'(1);
            if (err_reg != llp_pkg::ERR_MAX)   err_next  = err_reg + llp_pkg::ERR_W'(1);
        end

        // pop: empty stack completes the parse, else read the next entry
        if (do_pop) begin
            if (sp_reg == '0) begin
                complete_next = 1'b1;
                active_next   = 1'b0;
                state_next    = llp_pkg::ST_DONE;
            end else begin
                ram_re       = 1'b1;
                sp_next      = sp_m1;
                src_mem_next = 1'b1;
                state_next   = llp_pkg::ST_EXEC;
            end
        end
    end

endmodule

[sv/ll1_expression_parser.sv]
// Top level of the LL(1) expression parser: stack RAM, sequencer and result register.
//
// Usage
//   s_ channel: one token per beat, s_tdata[4:0] = token_code. The parser takes a
//   token only while it is idle (s_tready high); each token yields one result beat.
//   m_ channel: one result beat per token, held in an output register so the next
//   token can be taken while the result still waits for m_tready.
// Per-token sequence
//   Each token passes through accept, a first pop (the first token of a parse skips
//   it), one stack step per pop, match or expansion of up to two symbols, and the
//   result hand-off; a three-symbol expansion adds a second push step. A closing
//   token that unwinds a deep stack takes one step per entry popped. The loop is
//   bound by the single read and write port of the symbol stack RAM (1024 x 6,
//   registered read).
// Reset
//   aresetn (synchronous, active low) empties the stack, clears the error total and
//   marks no parse active: the next token starts a new parse. No RAM clearing pass.
// Stall
//   If m_tready stays low, a finished token waits in the sequencer until the output
//   register frees up; s_tready stays low during that time.
module ll1_expression_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // input tokens
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] token_code
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] token_matched, [11:1] new_errors,
                                   // [27:12] error_total, [28] parse_complete,
                                   // [29] stack_overflow
);

    logic                        res_valid;
    logic                        res_ready;
    llp_pkg::result_t            res;
    logic                        ram_we;
    logic [llp_pkg::ADDR_W-1:0]  ram_waddr;
    logic [llp_pkg::SYM_W-1:0]   ram_wdata;
    logic                        ram_re;
    logic [llp_pkg::ADDR_W-1:0]  ram_raddr;
    logic [llp_pkg::SYM_W-1:0]   ram_rdata;
    logic                        out_vld_reg;
    logic [31:0]                 out_data_reg;

    llp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_token  (s_tdata[llp_pkg::TOK_W-1:0]),
        .in_ready  (s_tready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    llp_ram #(
        .WIDTH (llp_pkg::SYM_W),
        .DEPTH (llp_pkg::STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: free when empty or being drained this cycle
    assign res_ready = !out_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_data_reg <= {2'b00, res};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sv/llp_checker.sv]
// Port-level checks on the expression parser, bound to its top level.
module llp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one token in flight: ready drops after a token is taken
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("token taken while another is being parsed");

    // overflow ends the parse without completing it
    a_ovf_not_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[29] |-> !m_tdata[28] && !m_tdata[0])
        else $error("overflow reported together with completion or match");

    // errors of this token are part of the parse total
    a_err_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[27:12] >= {5'b00000, m_tdata[11:1]})
        else $error("error total below this token's error count");

    // unused result bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:30] == 2'b00)
        else $error("result padding bits set");

endmodule

bind ll1_expression_parser llp_checker u_llp_checker (.*);
